@@ hw/rtl/rles_pkg.sv @@
// ----------------------------------------------------------------------------
// rles_pkg
// Shared types, constants and arithmetic helpers of the RGB light effect
// sequencer: transaction structs, effect codes and the LFSR / modulo helpers.
// ----------------------------------------------------------------------------
package rles_pkg;

    // Top of the rainbow and up-down ramps, full level of the xmas effect
    localparam int DUTY_MAX = 255;
    localparam int DUTY_W   = 8;
    localparam int DUTY_TOP = (1 << DUTY_W) - 1;

    // Ramp index must hold DUTY_MAX and any pulse top level
    localparam int RAMP_W_RAW = $clog2(DUTY_MAX + 1);
    localparam int RAMP_W     = (RAMP_W_RAW > DUTY_W) ? RAMP_W_RAW : DUTY_W;

    // Command number decoding
    localparam int DIGIT_BASE  = 48;
    localparam int NUM_W       = 15;
    localparam int NUM_BIAS    = DIGIT_BASE * 100 + DIGIT_BASE * 10 + DIGIT_BASE;
    localparam int LEVEL_TOP   = 255;
    localparam int PERIOD_TOP  = 1023;

    // Timed effects
    localparam int COLOR_DELAY_BASE = 800;
    localparam int COLOR_MOD        = 255;
    localparam int XMAS_DELAY_MOD   = 1000;
    localparam int XMAS_MOD         = 3;
    localparam int RECIP_SHIFT      = 26;
    localparam int RECIP_1000       = ((1 << RECIP_SHIFT) + XMAS_DELAY_MOD - 1)
                                      / XMAS_DELAY_MOD;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Widths of the state
    localparam int TICK_W   = 11;
    localparam int PERIOD_W = 10;
    localparam int PHASE_W  = 3;
    localparam int LFSR_W   = 16;

    // Command characters
    localparam logic [7:0] CHAR_0 = 8'h30;   // '0'
    localparam logic [7:0] CHAR_5 = 8'h35;   // '5'
    localparam logic [7:0] CHAR_M = 8'h6D;   // 'm'
    localparam logic [7:0] CHAR_R = 8'h72;   // 'r'
    localparam logic [7:0] CHAR_G = 8'h67;   // 'g'
    localparam logic [7:0] CHAR_B = 8'h62;   // 'b'
    localparam logic [7:0] CHAR_T = 8'h74;   // 't'
    localparam logic [7:0] CHAR_S = 8'h73;   // 's'

    // Channel indexes
    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;
    localparam int NUM_CH = 3;

    // Result event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_EFFECT  = 2'd1;
    localparam logic [1:0] EV_SETTING = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FLOOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 2'd1;

    typedef enum logic [2:0] {
        EFF_RAINBOW = 3'd0,
        EFF_UPDOWN  = 3'd1,
        EFF_MANUAL  = 3'd2,
        EFF_PULSE   = 3'd3,
        EFF_XMAS    = 3'd4,
        EFF_RANDOM  = 3'd5
    } effect_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red_duty;
        logic [7:0] green_duty;
        logic [7:0] blue_duty;
        logic [1:0] event_res;
    } out_item_t;

    // Classified item handed from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
    } op_item_t;

    // One Galois LFSR step, zero is replaced by one
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] n;
        n = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
        return (n == '0) ? LFSR_W'(1) : n;
    endfunction

    // v % 255 by folding bytes (256 = 1 mod 255)
    function automatic logic [7:0] mod255(input logic [15:0] v);
        logic [8:0] s;
        logic [8:0] t;
        s = 9'(v[15:8]) + 9'(v[7:0]);
        t = 9'(s[7:0]) + 9'(s[8]);
        return (t == 9'(COLOR_MOD)) ? 8'd0 : t[7:0];
    endfunction

    // v % 3 by folding bytes, then bit pairs (4 = 1 mod 3)
    function automatic logic [1:0] mod3(input logic [15:0] v);
        logic [8:0] s;
        logic [3:0] a;
        logic [2:0] b;
        s = 9'(v[15:8]) + 9'(v[7:0]);
        a = 4'(s[8]) + 4'(s[7:6]) + 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
        b = 3'(a[3:2]) + 3'(a[1:0]);
        if (b >= 3'd6)
        begin
            return 2'd0;
        end
        else if (b >= 3'd3)
        begin
            return 2'(b - 3'd3);
        end
        return b[1:0];
    endfunction

    // v % 1000 through a reciprocal multiply (exact for 16-bit v)
    function automatic logic [9:0] mod1000(input logic [15:0] v);
        logic [32:0] prod;
        logic [6:0]  q;
        logic [16:0] qk;
        logic [15:0] r;
        prod = 33'(v) * 33'(RECIP_1000);
        q    = prod[32:26];
        qk   = 17'(q) * 17'(XMAS_DELAY_MOD);
        r    = v - qk[15:0];
        return r[9:0];
    endfunction

    // Duty write saturation
    function automatic logic [DUTY_W-1:0] sat_duty(input logic [RAMP_W:0] v);
        return (v > (RAMP_W+1)'(DUTY_TOP)) ? DUTY_W'(DUTY_TOP) : v[DUTY_W-1:0];
    endfunction

    // Three-digit command number, clamped to 0..hi
    function automatic logic [PERIOD_W-1:0] sat_num(input logic [NUM_W-1:0] raw,
                                                    input logic [PERIOD_W-1:0] hi);
        logic [NUM_W-1:0] d;
        d = raw - NUM_W'(NUM_BIAS);
        if (raw < NUM_W'(NUM_BIAS))
        begin
            return '0;
        end
        else if (d > NUM_W'(hi))
        begin
            return hi;
        end
        return d[PERIOD_W-1:0];
    endfunction

    // Rainbow cross-fade channel pairs per phase
    function automatic logic [1:0] rainbow_up_ch(input logic [1:0] p);
        case (p)
            2'd1:    return CH_R;
            2'd2:    return CH_B;
            default: return CH_G;
        endcase
    endfunction

    function automatic logic [1:0] rainbow_down_ch(input logic [1:0] p);
        case (p)
            2'd1:    return CH_G;
            2'd2:    return CH_R;
            default: return CH_B;
        endcase
    endfunction

    // Up-down channel order: green, red, blue
    function automatic logic [1:0] updown_ch(input logic [1:0] half);
        case (half)
            2'd1:    return CH_R;
            2'd2:    return CH_B;
            default: return CH_G;
        endcase
    endfunction

endpackage

@@ hw/rtl/rles_front.sv @@
// ----------------------------------------------------------------------------
// rles_front
// Input side: accepts transactions, classifies them as command byte or tick
// and holds them in a two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
module rles_front
    import rles_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    output op_item_t q_item,
    input  logic     q_pop
);

    op_item_t    entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        push;
    logic        pop;
    op_item_t    classified;

    // Classify incoming transaction
    always_comb
    begin
        classified.op      = in_data.mode ? OP_TICK : OP_BYTE;
        classified.rx_byte = in_data.rx_byte;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

endmodule

@@ hw/rtl/rles_back.sv @@
// ----------------------------------------------------------------------------
// rles_back
// Execution side: command window decode, effect ramps, timed random effects,
// configuration registers and the output register of the result channel.
// ----------------------------------------------------------------------------
module rles_back
    import rles_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  op_item_t              q_item,
    output logic                  q_pop,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    logic [7:0]          window_reg [4];
    logic [7:0]          window_next [4];
    effect_t             active_reg;
    effect_t             active_next;
    effect_t             fallback_reg;
    effect_t             fallback_next;
    logic [DUTY_W-1:0]   level_reg [NUM_CH];
    logic [DUTY_W-1:0]   level_next [NUM_CH];
    logic [DUTY_W-1:0]   duty_reg [NUM_CH];
    logic [DUTY_W-1:0]   duty_next [NUM_CH];
    logic [7:0]          pulse_top_reg;
    logic [7:0]          pulse_top_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    logic [TICK_W-1:0]   tick_reg;
    logic [TICK_W-1:0]   tick_next;
    logic [RAMP_W-1:0]   idx_reg;
    logic [RAMP_W-1:0]   idx_next;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [LFSR_W-1:0]   lfsr_reg;
    logic [LFSR_W-1:0]   lfsr_next;
    logic [7:0]          floor_reg;
    logic [7:0]          floor_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_data_reg;
    out_item_t           out_data_next;

    // Decode helpers
    logic [7:0]          nw [4];
    logic [NUM_W-1:0]    num_raw;
    logic [7:0]          num_level;
    logic [PERIOD_W-1:0] num_period;
    logic [1:0]          ev;
    logic                is_effect_cmd;
    logic [2:0]          effect_code;
    logic [1:0]          level_ch;

    // Tick helpers
    logic [TICK_W:0]     tick_inc;
    logic [1:0]          rb_p;
    logic [PHASE_W-1:0]  ud_p;
    logic [1:0]          ud_ch;
    logic [1:0]          ud_next_ch;
    logic [PHASE_W-1:0]  ud_np;
    logic [RAMP_W:0]     idx_inc;
    logic [RAMP_W:0]     idx_dec;
    logic [RAMP_W:0]     rb_down;
    logic [RAMP_W:0]     top_w;
    logic [RAMP_W:0]     pulse_val;
    logic [LFSR_W-1:0]   l1;
    logic [LFSR_W-1:0]   l2;
    logic [LFSR_W-1:0]   l3;
    logic [LFSR_W-1:0]   l4;

    assign q_pop     = q_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Command window shift and number
    always_comb
    begin
        nw[0] = window_reg[1];
        nw[1] = window_reg[2];
        nw[2] = window_reg[3];
        nw[3] = q_item.rx_byte;
        num_raw = NUM_W'(nw[1]) * NUM_W'(100) + NUM_W'(nw[2]) * NUM_W'(10)
                + NUM_W'(nw[3]);
        num_level  = 8'(sat_num(num_raw, PERIOD_W'(LEVEL_TOP)));
        num_period = sat_num(num_raw, PERIOD_W'(PERIOD_TOP));
        is_effect_cmd = (nw[0] == CHAR_M) && (nw[1] == CHAR_0) && (nw[2] == CHAR_0)
                     && (nw[3] >= CHAR_0) && (nw[3] <= CHAR_5);
        effect_code = 3'(nw[3] - CHAR_0);
        if (nw[0] == CHAR_R)
        begin
            level_ch = CH_R;
        end
        else if (nw[0] == CHAR_G)
        begin
            level_ch = CH_G;
        end
        else
        begin
            level_ch = CH_B;
        end
    end

    // Ramp and LFSR helpers
    always_comb
    begin
        tick_inc   = (TICK_W+1)'(tick_reg) + (TICK_W+1)'(1);
        rb_p       = (phase_reg < PHASE_W'(3)) ? phase_reg[1:0] : 2'd0;
        ud_p       = (phase_reg < PHASE_W'(6)) ? phase_reg : '0;
        ud_ch      = updown_ch(ud_p[2:1]);
        ud_np      = (ud_p == PHASE_W'(5)) ? '0 : ud_p + PHASE_W'(1);
        ud_next_ch = updown_ch(ud_np[2:1]);
        idx_inc    = (RAMP_W+1)'(idx_reg) + (RAMP_W+1)'(1);
        idx_dec    = (idx_reg != '0) ? (RAMP_W+1)'(idx_reg) - (RAMP_W+1)'(1) : '0;
        rb_down    = (RAMP_W+1)'(DUTY_MAX) - idx_inc;
        top_w      = (RAMP_W+1)'(pulse_top_reg);
        if (phase_reg == '0)
        begin
            pulse_val = ((RAMP_W+1)'(idx_reg) < top_w) ? idx_inc : (RAMP_W+1)'(idx_reg);
        end
        else
        begin
            pulse_val = ((RAMP_W+1)'(idx_reg) > top_w) ? top_w : (RAMP_W+1)'(idx_reg);
            if (pulse_val != '0)
            begin
                pulse_val = pulse_val - (RAMP_W+1)'(1);
            end
        end
        l1 = lfsr_step(lfsr_reg);
        l2 = lfsr_step(l1);
        l3 = lfsr_step(l2);
        l4 = lfsr_step(l3);
    end

    // Item execution and configuration writes
    always_comb
    begin
        window_next    = window_reg;
        active_next    = active_reg;
        fallback_next  = fallback_reg;
        level_next     = level_reg;
        duty_next      = duty_reg;
        pulse_top_next = pulse_top_reg;
        period_next    = period_reg;
        tick_next      = tick_reg;
        idx_next       = idx_reg;
        phase_next     = phase_reg;
        lfsr_next      = lfsr_reg;
        floor_next     = floor_reg;
        ev             = EV_NONE;

        if (q_pop)
        begin
            if (q_item.op == OP_BYTE)
            begin
                // Decode the window
                active_next = fallback_reg;
                if (is_effect_cmd)
                begin
                    active_next = effect_t'(effect_code);
                    if (effect_t'(effect_code) != EFF_UPDOWN)
                    begin
                        fallback_next = effect_t'(effect_code);
                    end
                    ev = EV_EFFECT;
                end
                else if ((nw[0] == CHAR_R) || (nw[0] == CHAR_G) || (nw[0] == CHAR_B))
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        if (level_ch == 2'(c))
                        begin
                            level_next[c] = num_level;
                            duty_next[c]  = num_level;
                        end
                    end
                    ev = EV_SETTING;
                end
                else if (nw[0] == CHAR_T)
                begin
                    pulse_top_next = num_level;
                    ev = EV_SETTING;
                end
                else if (nw[0] == CHAR_S)
                begin
                    period_next = num_period;
                    ev = EV_SETTING;
                end

                if (ev != EV_NONE)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        window_next[i] = '0;
                    end
                end
                else
                begin
                    window_next = nw;
                end

                // Restart the running effect
                tick_next  = '0;
                idx_next   = '0;
                phase_next = '0;
                case (active_next)
                    EFF_UPDOWN:
                    begin
                        duty_next[CH_G] = '0;
                    end
                    EFF_PULSE:
                    begin
                        if (pulse_top_next != '0)
                        begin
                            for (int c = 0; c < NUM_CH; c++)
                            begin
                                if (level_next[c] > floor_reg)
                                begin
                                    duty_next[c] = '0;
                                end
                            end
                        end
                    end
                    EFF_MANUAL:
                    begin
                        duty_next = level_next;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                case (active_reg)
                    EFF_RAINBOW, EFF_UPDOWN, EFF_PULSE:
                    begin
                        tick_next = TICK_W'(tick_inc);
                        if (tick_inc > (TICK_W+1)'(period_reg))
                        begin
                            tick_next = '0;
                            if (active_reg == EFF_RAINBOW)
                            begin
                                // Cross-fade one channel up, one down
                                for (int c = 0; c < NUM_CH; c++)
                                begin
                                    if (rainbow_up_ch(rb_p) == 2'(c))
                                    begin
                                        duty_next[c] = sat_duty(idx_inc);
                                    end
                                    if (rainbow_down_ch(rb_p) == 2'(c))
                                    begin
                                        duty_next[c] = sat_duty(rb_down);
                                    end
                                end
                                if (idx_inc >= (RAMP_W+1)'(DUTY_MAX))
                                begin
                                    idx_next   = '0;
                                    phase_next = (rb_p == 2'd2) ? '0
                                               : PHASE_W'(rb_p) + PHASE_W'(1);
                                end
                                else
                                begin
                                    idx_next = RAMP_W'(idx_inc);
                                end
                            end
                            else if (active_reg == EFF_UPDOWN)
                            begin
                                // Ramp one channel up then down, in turn
                                if (!ud_p[0])
                                begin
                                    idx_next = RAMP_W'(idx_inc);
                                    for (int c = 0; c < NUM_CH; c++)
                                    begin
                                        if (ud_ch == 2'(c))
                                        begin
                                            duty_next[c] = sat_duty(idx_inc);
                                        end
                                    end
                                    if (idx_inc >= (RAMP_W+1)'(DUTY_MAX))
                                    begin
                                        phase_next = ud_p + PHASE_W'(1);
                                    end
                                end
                                else
                                begin
                                    idx_next = RAMP_W'(idx_dec);
                                    for (int c = 0; c < NUM_CH; c++)
                                    begin
                                        if (ud_ch == 2'(c))
                                        begin
                                            duty_next[c] = sat_duty(idx_dec);
                                        end
                                        if ((idx_dec == '0) && (ud_next_ch == 2'(c)))
                                        begin
                                            duty_next[c] = '0;
                                        end
                                    end
                                    if (idx_dec == '0)
                                    begin
                                        phase_next = ud_np;
                                    end
                                end
                            end
                            else if (pulse_top_reg != '0)
                            begin
                                // Pulse between zero and the pulse top
                                idx_next = RAMP_W'(pulse_val);
                                for (int c = 0; c < NUM_CH; c++)
                                begin
                                    if (level_reg[c] > floor_reg)
                                    begin
                                        duty_next[c] = sat_duty(pulse_val);
                                    end
                                end
                                if (phase_reg == '0)
                                begin
                                    if (pulse_val >= top_w)
                                    begin
                                        phase_next = PHASE_W'(1);
                                    end
                                end
                                else if (pulse_val == '0)
                                begin
                                    phase_next = '0;
                                end
                            end
                        end
                    end
                    EFF_MANUAL:
                    begin
                        duty_next = level_reg;
                    end
                    EFF_XMAS, EFF_RANDOM:
                    begin
                        if (tick_reg != '0)
                        begin
                            tick_next = tick_reg - TICK_W'(1);
                        end
                        else if (active_reg == EFF_RANDOM)
                        begin
                            duty_next[CH_R] = mod255(l1);
                            duty_next[CH_G] = mod255(l2);
                            duty_next[CH_B] = mod255(l3);
                            tick_next = TICK_W'({mod255(l4), 1'b0})
                                      + TICK_W'(COLOR_DELAY_BASE);
                            lfsr_next = l4;
                        end
                        else
                        begin
                            case (mod3(l1))
                                2'd0:
                                begin
                                    duty_next[CH_R] = DUTY_W'(DUTY_MAX > DUTY_TOP
                                                              ? DUTY_TOP : DUTY_MAX);
                                    duty_next[CH_G] = '0;
                                end
                                2'd1:
                                begin
                                    duty_next[CH_R] = '0;
                                    duty_next[CH_G] = '0;
                                end
                                default:
                                begin
                                    duty_next[CH_R] = '0;
                                    duty_next[CH_G] = DUTY_W'(DUTY_MAX > DUTY_TOP
                                                              ? DUTY_TOP : DUTY_MAX);
                                end
                            endcase
                            tick_next = TICK_W'(mod1000(l2));
                            lfsr_next = l2;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // Configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PULSE_FLOOR:
                begin
                    floor_next = cfg_data[7:0];
                end
                CFG_RANDOM_SEED:
                begin
                    lfsr_next = (cfg_data[LFSR_W-1:0] == '0) ? LFSR_W'(1)
                              : cfg_data[LFSR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = q_pop ? 1'b1 : (out_valid_reg && out_stall);
        out_data_next.red_duty   = duty_next[CH_R];
        out_data_next.green_duty = duty_next[CH_G];
        out_data_next.blue_duty  = duty_next[CH_B];
        out_data_next.event_res  = ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                window_reg[i] <= '0;
            end
            for (int c = 0; c < NUM_CH; c++)
            begin
                level_reg[c] <= '0;
                duty_reg[c]  <= '0;
            end
            active_reg    <= EFF_RAINBOW;
            fallback_reg  <= EFF_RAINBOW;
            pulse_top_reg <= 8'(LEVEL_TOP);
            period_reg    <= PERIOD_W'(10);
            tick_reg      <= '0;
            idx_reg       <= '0;
            phase_reg     <= '0;
            lfsr_reg      <= LFSR_W'(1);
            floor_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            level_reg     <= level_next;
            duty_reg      <= duty_next;
            active_reg    <= active_next;
            fallback_reg  <= fallback_next;
            pulse_top_reg <= pulse_top_next;
            period_reg    <= period_next;
            tick_reg      <= tick_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            lfsr_reg      <= lfsr_next;
            floor_reg     <= floor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ hw/rtl/rgb_light_effect_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_light_effect_sequencer_unit
// RGB light effect sequencer: serial command bytes and millisecond ticks in,
// three duty levels and a decode event out, one result per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid / in_stall, in_data carries mode (0 byte, 1 tick)
//                 and rx_byte. A transaction completes when valid && !stall.
//   out channel : out_valid / out_stall, out_data carries the three duty
//                 levels and event_res; exactly one result per input item.
//   cfg channel : cfg_valid / cfg_ready (always ready), cfg_index selects
//                 pulse_floor (0) or random_seed (1); the seed also reloads
//                 the LFSR. Write only while no transaction is in flight.
//   Path        : an accepted input goes through the queue entry, then is
//                 executed into the output register.
//   Throughput  : 1 item per cycle while out_stall is low; each item is one
//                 pass of the execute stage, ticks with random colour included.
//   Reset       : rst_n clears the queue and output valid and loads all
//                 effect state to its power-up values (rainbow effect).
//   Stall       : the result register holds while out_stall is high; the
//                 two-entry queue absorbs input, then in_stall rises.
// ----------------------------------------------------------------------------
module rgb_light_effect_sequencer_unit
    import rles_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic     q_valid;
    logic     q_pop;
    op_item_t q_item;

    assign cfg_ready = 1'b1;

    // Accept and classify
    rles_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Execute and hold result
    rles_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
